FILE: src/cfba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator package
// Constants, codes, types and helper functions shared by the frame bitmap
// allocator.
// ----------------------------------------------------------------------------
package cfba_pkg;

	// Default map size in frames.
	localparam int MAX_FRAMES_DEF = 16384;
	// Width of frame arithmetic; covers the largest map plus a run length.
	localparam int EW = 17;

	// Window bounds, in frames and in map bytes.
	localparam int KWIN_LO_FRAME = 264;
	localparam int KWIN_LO_BYTE  = 33;
	localparam int KWIN_END_BYTE = 127;
	localparam int UWIN_LO_FRAME = 1024;
	localparam int UWIN_LO_BYTE  = 128;

	// Map contents after init.
	localparam int         RESERVED_BYTES = 32;
	localparam logic [7:0] RESERVED_TAIL  = 8'h1F;

	// Reset value of the installed frame count.
	localparam logic [14:0] TOTAL_RESET = 15'd16384;

	// Command codes.
	localparam logic [2:0] FN_INIT       = 3'd0;
	localparam logic [2:0] FN_ALLOC_KERN = 3'd1;
	localparam logic [2:0] FN_ALLOC_USER = 3'd2;
	localparam logic [2:0] FN_FREE       = 3'd3;
	localparam logic [2:0] FN_COUNT      = 3'd4;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		OP_SEARCH,
		OP_MARK,
		OP_FREE,
		OP_COUNT
	} op_t;

	// Number of set bits in one map byte.
	function automatic logic [3:0] popcount8(input logic [7:0] b);
		logic [3:0] c;
		c = 4'd0;
		for (int k = 0; k < 8; k++) begin
			c = c + {3'd0, b[k]};
		end
		return c;
	endfunction

	// Bits of the byte starting at frame base that fall in frames [lo, hi).
	// Frame base+k sits at bit 7-k.
	function automatic logic [7:0] run_mask(input logic [EW-1:0] base,
			input logic [EW-1:0] lo, input logic [EW-1:0] hi);
		logic [7:0]    m;
		logic [EW-1:0] f;
		m = 8'd0;
		for (int k = 0; k < 8; k++) begin
			f = base + EW'(k);
			m[7-k] = (f >= lo) && (f < hi);
		end
		return m;
	endfunction

endpackage

FILE: src/contiguous_frame_bitmap_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Contiguous frame bitmap allocator
// First-fit allocator over a one-bit-per-frame map held in a byte-wide
// synchronous memory; supports init, kernel and user allocation, free and a
// free-frame count.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake                 | Payload
// ----------+---------------------------+-----------------------------------
// command   | start, busy               | func, frame_count, first_frame
// result    | done (one-cycle strobe)   | found_frame, ok, free_frames
// config    | total_frames_we           | total_frames_wdata
//
// Init writes every map byte, one write per map byte, before the result.
// Count and a failed search read each scanned map byte; a successful
// allocation then rewrites each byte of the marked run, and free rewrites
// each touched byte. A rejected allocation or an unknown command answers
// without a scan. The single read port of the map sets the pace of one byte
// per cycle. After reset the map is filled with the init pattern with busy
// high and no result. Results cannot be stalled; done pulses for one cycle
// per item.
//
module contiguous_frame_bitmap_allocator_top
	import cfba_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  func,
	input  logic [14:0] frame_count,
	input  logic [13:0] first_frame,
	input  logic        total_frames_we,
	input  logic [14:0] total_frames_wdata,
	output logic        done,
	output logic [13:0] found_frame,
	output logic        ok,
	output logic [14:0] free_frames
);

	localparam int MAP_BYTES = MAX_FRAMES / 8;
	localparam int AW = $clog2(MAP_BYTES);
	localparam int FW = AW + 3;

	// Map memory.
	logic [7:0] mem [MAP_BYTES];
	logic [7:0] rd_q;
	logic       rd_en;
	logic [AW-1:0] rd_addr;
	logic       wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0] wr_data;

	// Control and pipeline state.
	state_t        state_q, state_d;
	op_t           op_q, op_d;
	logic [AW:0]   addr_q, addr_d;
	logic [AW:0]   end_q, end_d;
	logic          v_s1, v_d;
	logic [AW-1:0] a_s1;
	logic [14:0]   run_q, run_d;
	logic [FW-1:0] first_q, first_d;
	logic [EW-1:0] cnt_q, cnt_d;
	logic [14:0]   n_q, n_d;
	logic [EW-1:0] lo_q, lo_d, hi_q, hi_d;
	logic          pend_q, pend_d;
	logic [13:0]   res_found_q, res_found_d;
	logic          res_ok_q, res_ok_d;
	logic [14:0]   res_free_q, res_free_d;
	logic [14:0]   total_q;

	// Command decode helpers.
	logic [EW-1:0] tf, lo_f, limit;
	logic [AW:0]   tf_bytes, win_lo_b, win_end_b;
	logic          is_user, alloc_bad;
	logic [EW-1:0] f_lo, f_sum, f_hi;
	logic [AW:0]   f_lo_b, f_end_b;
	logic          free_none;

	// Scan helpers.
	logic          issue, scan_fin, clear_last, srch_hit, hit_raw;
	logic [14:0]   run_n;
	logic [FW-1:0] first_n;
	logic [EW-1:0] m_lo, m_hi, first_x;
	logic [AW:0]   m_lo_b, m_end_b;
	logic [7:0]    mask, clr_data;

	// Memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Window, limit and free range for an incoming command.
	always_comb begin
		tf = (EW'(total_q) > EW'(MAX_FRAMES)) ? EW'(MAX_FRAMES) : EW'(total_q);
		tf_bytes  = (AW+1)'(tf >> 3);
		is_user   = (func == FN_ALLOC_USER);
		win_lo_b  = is_user ? (AW+1)'(UWIN_LO_BYTE) : (AW+1)'(KWIN_LO_BYTE);
		win_end_b = is_user ? tf_bytes : (AW+1)'(KWIN_END_BYTE);
		lo_f      = is_user ? EW'(UWIN_LO_FRAME) : EW'(KWIN_LO_FRAME);
		limit     = (tf > lo_f) ? tf - lo_f : '0;
		alloc_bad = (frame_count == 15'd0) || (EW'(frame_count) > limit) ||
			(win_lo_b >= win_end_b);
		f_lo      = EW'(first_frame);
		f_sum     = f_lo + EW'(frame_count);
		f_hi      = (f_sum > EW'(MAX_FRAMES)) ? EW'(MAX_FRAMES) : f_sum;
		free_none = (f_lo >= f_hi);
		f_lo_b    = (AW+1)'(f_lo >> 3);
		f_end_b   = (AW+1)'(((f_hi - EW'(1)) >> 3) + EW'(1));
	end

	// First-fit step over the eight frames of the byte just read.
	always_comb begin
		run_n   = run_q;
		first_n = first_q;
		hit_raw = 1'b0;
		for (int k = 0; k < 8; k++) begin
			if (!hit_raw) begin
				if (rd_q[7-k]) begin
					if (run_n == 15'd0) begin
						first_n = {a_s1, 3'(k)};
					end
					run_n = run_n + 15'd1;
					if (run_n == n_q) begin
						hit_raw = 1'b1;
					end
				end else begin
					run_n = 15'd0;
				end
			end
		end
		srch_hit = v_s1 && (op_q == OP_SEARCH) && hit_raw;
		m_lo     = EW'(first_n);
		m_hi     = m_lo + EW'(n_q);
		m_lo_b   = (AW+1)'(m_lo >> 3);
		m_end_b  = (AW+1)'(((m_hi - EW'(1)) >> 3) + EW'(1));
	end

	// Scan sequencing and memory port selection.
	always_comb begin
		issue      = (state_q == ST_SCAN) && (addr_q < end_q) && !srch_hit;
		scan_fin   = (state_q == ST_SCAN) && !(addr_q < end_q) && !v_s1;
		clear_last = (addr_q == (AW+1)'(MAP_BYTES - 1));
		rd_en      = issue;
		rd_addr    = addr_q[AW-1:0];
		mask       = run_mask(EW'({a_s1, 3'b000}), lo_q, hi_q);
		first_x    = EW'(first_q);
		if (addr_q < (AW+1)'(RESERVED_BYTES)) begin
			clr_data = 8'h00;
		end else if (addr_q == (AW+1)'(RESERVED_BYTES)) begin
			clr_data = RESERVED_TAIL;
		end else begin
			clr_data = 8'hFF;
		end
		wr_en   = 1'b0;
		wr_addr = addr_q[AW-1:0];
		wr_data = clr_data;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == ST_SCAN && v_s1 && op_q == OP_FREE) begin
			wr_en   = 1'b1;
			wr_addr = a_s1;
			wr_data = rd_q | mask;
		end else if (state_q == ST_SCAN && v_s1 && op_q == OP_MARK) begin
			wr_en   = 1'b1;
			wr_addr = a_s1;
			wr_data = rd_q & ~mask;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clear_last) begin
					state_d = pend_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					unique case (func) inside
						FN_INIT: state_d = ST_CLEAR;
						FN_ALLOC_KERN, FN_ALLOC_USER: state_d = alloc_bad ? ST_DONE : ST_SCAN;
						FN_FREE: state_d = free_none ? ST_DONE : ST_SCAN;
						FN_COUNT: state_d = ST_SCAN;
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_fin) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath register updates.
	always_comb begin
		op_d        = op_q;
		addr_d      = addr_q;
		end_d       = end_q;
		v_d         = 1'b0;
		run_d       = run_q;
		first_d     = first_q;
		cnt_d       = cnt_q;
		n_d         = n_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		pend_d      = pend_q;
		res_found_d = res_found_q;
		res_ok_d    = res_ok_q;
		res_free_d  = res_free_q;
		unique case (state_q)
			ST_CLEAR: begin
				addr_d = addr_q + (AW+1)'(1);
				if (clear_last) begin
					res_found_d = '0;
					res_ok_d    = 1'b1;
					res_free_d  = '0;
				end
			end
			ST_IDLE: begin
				if (start) begin
					n_d         = frame_count;
					run_d       = '0;
					cnt_d       = '0;
					pend_d      = (func == FN_INIT);
					res_found_d = '0;
					res_ok_d    = 1'b0;
					res_free_d  = '0;
					unique case (func) inside
						FN_INIT: begin
							addr_d = '0;
						end
						FN_ALLOC_KERN, FN_ALLOC_USER: begin
							op_d   = OP_SEARCH;
							addr_d = win_lo_b;
							end_d  = win_end_b;
						end
						FN_FREE: begin
							op_d     = OP_FREE;
							addr_d   = f_lo_b;
							end_d    = f_end_b;
							lo_d     = f_lo;
							hi_d     = f_hi;
							res_ok_d = 1'b1;
						end
						FN_COUNT: begin
							op_d   = OP_COUNT;
							addr_d = '0;
							end_d  = tf_bytes;
						end
						default: begin
							op_d = op_q;
						end
					endcase
				end
			end
			ST_SCAN: begin
				v_d = issue;
				if (issue) begin
					addr_d = addr_q + (AW+1)'(1);
				end
				if (v_s1 && op_q == OP_SEARCH) begin
					run_d   = run_n;
					first_d = first_n;
				end
				if (v_s1 && op_q == OP_COUNT) begin
					cnt_d = cnt_q + EW'(popcount8(rd_q));
				end
				// A hit turns the scan into a clearing pass over the run.
				if (srch_hit) begin
					op_d   = OP_MARK;
					addr_d = m_lo_b;
					end_d  = m_end_b;
					lo_d   = m_lo;
					hi_d   = m_hi;
					v_d    = 1'b0;
				end
				if (scan_fin) begin
					case (op_q)
						OP_MARK: begin
							res_ok_d    = 1'b1;
							res_found_d = first_x[13:0];
						end
						OP_COUNT: begin
							res_ok_d   = 1'b1;
							res_free_d = cnt_q[14:0];
						end
						OP_FREE: res_ok_d = 1'b1;
						default: res_ok_d = 1'b0;
					endcase
				end
			end
			default: begin
				v_d = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
			v_s1    <= 1'b0;
			pend_q  <= 1'b0;
			total_q <= TOTAL_RESET;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			v_s1    <= v_d;
			pend_q  <= pend_d;
			if (total_frames_we) begin
				total_q <= total_frames_wdata;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		op_q        <= op_d;
		end_q       <= end_d;
		a_s1        <= addr_q[AW-1:0];
		run_q       <= run_d;
		first_q     <= first_d;
		cnt_q       <= cnt_d;
		n_q         <= n_d;
		lo_q        <= lo_d;
		hi_q        <= hi_d;
		res_found_q <= res_found_d;
		res_ok_q    <= res_ok_d;
		res_free_q  <= res_free_d;
	end

	// Outputs.
	always_comb begin
		busy        = (state_q != ST_IDLE);
		done        = (state_q == ST_DONE);
		found_frame = res_found_q;
		ok          = res_ok_q;
		free_frames = res_free_q;
	end

	// A result is only shown while the block still counts as busy.
	assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("result strobe outside busy");

	// The read-modify-write pipeline never reads the byte it writes.
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("read and write of the same map byte");

	// An accepted command always makes the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command accepted without going busy");

	// No read data is in flight once the block is idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !v_s1)
		else $error("read data in flight while idle");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame allocator testbench
// Drives init, allocate, free, count and unknown commands through several
// settings of the installed frame count, predicts each result from a private
// copy of the frame map and compares every result strobe field by field.
// ----------------------------------------------------------------------------
module tb_top;
	import cfba_pkg::*;

	localparam int          MAP_FRAMES   = 16384;
	localparam int          KWIN_END     = 1016;
	localparam int          CYCLE_LIMIT  = 4000000;
	localparam logic [2:0]  FN_UNUSED_LO = 3'd5;

	// Expected fields of one result.
	typedef struct {
		logic [13:0] found_frame;
		logic        ok;
		logic [14:0] free_frames;
	} alloc_result_t;

	// Frame map predictor and store of pending results.
	class alloc_scoreboard;
		bit            frame_free[MAP_FRAMES];
		int            total;
		alloc_result_t awaited[$];
		int            mismatches;
		int            failures;

		function void init_map();
			for (int f = 0; f < MAP_FRAMES; f++) begin
				frame_free[f] = (f >= 259);
			end
		endfunction

		function void set_total(logic [14:0] v);
			total = v;
		endfunction

		// Predicts one accepted command; returns the allocated run start.
		function void note_command(logic [2:0] fn, int n, int loc,
				output int start, output bit success);
			alloc_result_t r;
			int tf, lo, hi, limit, run, first;
			tf = (total > MAP_FRAMES) ? MAP_FRAMES : total;
			r.found_frame = '0;
			r.ok = 1'b0;
			r.free_frames = '0;
			start = 0;
			success = 0;
			if (fn == FN_INIT) begin
				init_map();
				r.ok = 1'b1;
			end else if (fn == FN_ALLOC_KERN || fn == FN_ALLOC_USER) begin
				lo = (fn == FN_ALLOC_KERN) ? KWIN_LO_FRAME : UWIN_LO_FRAME;
				hi = (fn == FN_ALLOC_KERN) ? KWIN_END : (tf / 8) * 8;
				if (hi > MAP_FRAMES) hi = MAP_FRAMES;
				limit = (tf > lo) ? tf - lo : 0;
				run = 0;
				first = 0;
				if (n != 0 && n <= limit) begin
					for (int f = lo; f < hi && !success; f++) begin
						if (frame_free[f]) begin
							if (run == 0) first = f;
							run++;
							if (run == n) success = 1;
						end else begin
							run = 0;
						end
					end
				end
				if (success) begin
					for (int i = 0; i < n; i++) begin
						frame_free[first + i] = 0;
					end
					start = first;
					r.found_frame = first[13:0];
					r.ok = 1'b1;
				end
			end else if (fn == FN_FREE) begin
				for (int i = 0; i < n; i++) begin
					if (loc + i < MAP_FRAMES) frame_free[loc + i] = 1;
				end
				r.ok = 1'b1;
			end else if (fn == FN_COUNT) begin
				for (int f = 0; f < (tf / 8) * 8; f++) begin
					r.free_frames += frame_free[f];
				end
				r.ok = 1'b1;
			end
			awaited.push_back(r);
		endfunction

		// Compares one result strobe with the oldest expectation.
		function void check_result(logic [13:0] ff, logic okv, logic [14:0] cnt);
			alloc_result_t r;
			if (awaited.size() == 0) begin
				failures++;
				if (mismatches++ < 10)
					$display("ERROR: unexpected result found=%0d ok=%0b free=%0d",
						ff, okv, cnt);
				return;
			end
			r = awaited.pop_front();
			if (r.found_frame !== ff || r.ok !== okv || r.free_frames !== cnt) begin
				failures++;
				if (mismatches++ < 10)
					$display("ERROR: result mismatch exp found=%0d ok=%0b free=%0d, got found=%0d ok=%0b free=%0d",
						r.found_frame, r.ok, r.free_frames, ff, okv, cnt);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  func;
	logic [14:0] frame_count;
	logic [13:0] first_frame;
	logic        total_frames_we;
	logic [14:0] total_frames_wdata;
	logic        done;
	logic [13:0] found_frame;
	logic        ok;
	logic [14:0] free_frames;

	alloc_scoreboard sb;
	int          cycles;
	int          burst_left;
	int          run_starts[$];
	int          run_lengths[$];

	contiguous_frame_bitmap_allocator_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.func              (func),
		.frame_count       (frame_count),
		.first_frame       (first_frame),
		.total_frames_we   (total_frames_we),
		.total_frames_wdata(total_frames_wdata),
		.done              (done),
		.found_frame       (found_frame),
		.ok                (ok),
		.free_frames       (free_frames)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Results are sampled mid-cycle, away from the driving edge.
	always @(negedge clk) begin
		if (arst_n && done) sb.check_result(found_frame, ok, free_frames);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Sends one command; returns in the time step of the accepting edge.
	task automatic send_command(logic [2:0] fn, int n, int loc);
		bit was_busy;
		bit success;
		int st;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
		end
		burst_left--;
		start       <= 1'b1;
		func        <= fn;
		frame_count <= n[14:0];
		first_frame <= loc[13:0];
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
		sb.note_command(fn, n, loc, st, success);
		if (success) begin
			run_starts.push_back(st);
			run_lengths.push_back(n);
		end
		if (fn == FN_INIT) begin
			run_starts.delete();
			run_lengths.delete();
		end
	endtask

	// Stops sending and waits until every result has arrived.
	task automatic drain();
		start <= 1'b0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_total(logic [14:0] v);
		total_frames_we    <= 1'b1;
		total_frames_wdata <= v;
		@(posedge clk);
		total_frames_we <= 1'b0;
		sb.set_total(v);
	endtask

	// One random command, weighted toward alloc/free pairs.
	task automatic random_command();
		int r, k, n;
		r = $urandom_range(0, 99);
		n = ($urandom_range(0, 19) == 0) ? $urandom_range(1, MAP_FRAMES)
			: $urandom_range(1, 40);
		if (r < 40) begin
			send_command($urandom_range(0, 1) ? FN_ALLOC_USER : FN_ALLOC_KERN, n, 0);
		end else if (r < 68) begin
			if (run_starts.size() != 0) begin
				k = $urandom_range(0, run_starts.size() - 1);
				send_command(FN_FREE, run_lengths[k], run_starts[k]);
				run_starts.delete(k);
				run_lengths.delete(k);
			end else begin
				send_command(FN_FREE, $urandom_range(0, 40), $urandom_range(0, 16383));
			end
		end else if (r < 80) begin
			send_command(FN_COUNT, $urandom_range(0, 32767), $urandom_range(0, 16383));
		end else if (r < 86) begin
			send_command(FN_FREE, $urandom_range(0, 300), $urandom_range(0, 16383));
		end else if (r < 91) begin
			send_command(3'($urandom_range(FN_UNUSED_LO, 7)), $urandom_range(0, 32767),
				$urandom_range(0, 16383));
		end else if (r < 93) begin
			send_command(FN_INIT, $urandom_range(0, 32767), $urandom_range(0, 16383));
		end else begin
			send_command($urandom_range(0, 1) ? FN_ALLOC_USER : FN_ALLOC_KERN,
				$urandom_range(0, 1) ? 0 : $urandom_range(700, 16384), 0);
		end
	endtask

	initial begin
		logic [14:0] totals[7];
		totals = '{15'd264, 15'd1024, 15'd0, 15'd32767, 15'd2000, 15'd0, 15'd16384};
		totals[5] = 15'($urandom_range(0, 32767));
		sb = new();
		sb.init_map();
		sb.set_total(TOTAL_RESET);
		cycles = 0;
		burst_left = 0;
		arst_n = 1'b0;
		start = 1'b0;
		func = FN_INIT;
		frame_count = '0;
		first_frame = '0;
		total_frames_we = 1'b0;
		total_frames_wdata = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset map, window edges, zero and oversize lengths, unknown commands and init.
		send_command(FN_COUNT, 0, 0);
		send_command(FN_ALLOC_KERN, 0, 0);
		send_command(FN_ALLOC_KERN, 752, 0);
		send_command(FN_ALLOC_KERN, 1, 0);
		send_command(FN_FREE, 752, KWIN_LO_FRAME);
		send_command(FN_ALLOC_KERN, 753, 0);
		send_command(FN_ALLOC_KERN, 5, 0);
		send_command(FN_ALLOC_USER, 1, 0);
		send_command(FN_ALLOC_USER, 15360, 0);
		send_command(FN_ALLOC_USER, 15361, 0);
		send_command(FN_COUNT, 32767, 16383);
		send_command(FN_FREE, 16384, 16383);
		send_command(FN_FREE, 16384, 0);
		send_command(FN_COUNT, 0, 0);
		send_command(FN_FREE, 32767, 16383);
		send_command(FN_ALLOC_USER, 16384, 0);
		send_command(3'd5, 32767, 16383);
		send_command(3'd6, 1, 1);
		send_command(3'd7, 0, 0);
		send_command(FN_INIT, 32767, 16383);
		send_command(FN_COUNT, 0, 0);

		// Random phases, each under a different installed frame count.
		foreach (totals[p]) begin
			drain();
			write_total(totals[p]);
			send_command(FN_COUNT, 0, 0);
			send_command(FN_ALLOC_KERN, 1, 0);
			send_command(FN_ALLOC_USER, 1, 0);
			repeat (35) random_command();
		end

		drain();
		repeat (200) @(posedge clk);
		if (sb.failures == 0 && sb.awaited.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
